[design/hlpl_pkg.sv]
package hlpl_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_RINGS  = 64;
	localparam int MAX_LAYERS = 256;

	localparam int IN_W  = 32;
	localparam int D_W   = IN_W + 1;
	localparam int P_W   = 2 * D_W;
	localparam int PZ_W  = P_W - FRAC_BITS;
	localparam int XS_W  = FRAC_BITS + 22;
	localparam int LAY_W = PZ_W + 1 - FRAC_BITS;

	localparam int HK      = 75674;
	localparam int HK_W    = 18;
	localparam int HK_BITS = 16;
	localparam int HP_W    = XS_W + HK_W;

	localparam int C_W = XS_W + 5;
	localparam int R_W = C_W - FRAC_BITS + 1;
	localparam int E_W = FRAC_BITS + 1;

	localparam int RC_W  = 7;
	localparam int LC_W  = 9;
	localparam int W_W   = 8;
	localparam int WW_W  = 14;
	localparam int IDX_W = 22;
	localparam int OUT_W = 16;

	typedef enum logic [3:0] {
		REG_ORIGIN_X    = 4'd0,
		REG_ORIGIN_Y    = 4'd1,
		REG_ORIGIN_Z    = 4'd2,
		REG_INV_PITCH   = 4'd3,
		REG_INV_PITCH_Z = 4'd4,
		REG_RING_COUNT  = 4'd5,
		REG_LAYER_COUNT = 4'd6,
		REG_FLAT_TOP    = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [IN_W-1:0] origin_x;
		logic signed [IN_W-1:0] origin_y;
		logic signed [IN_W-1:0] origin_z;
		logic [IN_W-1:0]        inv_pitch;
		logic [IN_W-1:0]        inv_pitch_z;
		logic                   flat_top;
		logic [RC_W-1:0]        rc;
		logic [LC_W-1:0]        lc;
		logic [W_W-1:0]         w;
		logic [WW_W-1:0]        ww;
	} cfg_t;

	typedef struct packed {
		logic signed [XS_W-1:0]  xs;
		logic signed [XS_W-1:0]  ys;
		logic signed [LAY_W-1:0] layer;
	} front_t;

	typedef struct packed {
		logic signed [R_W-1:0]   rq;
		logic signed [R_W-1:0]   rr;
		logic [R_W-1:0]          ring;
		logic signed [LAY_W-1:0] layer;
	} hex_t;

endpackage

[design/hex_lattice_point_locator_unit.sv]
// Channel    Handshake              Payload
// input      start, busy            pos_x, pos_y, pos_z
// result     done (one cycle)       inside_res, axial_q, axial_r, ring, layer, cell_index
// config     cfg_valid, cfg_ready   cfg_addr, cfg_data
//
// One point enters every cycle; busy stays low and cfg_ready stays high.
// The pipeline stages, in order: offset, 33x33 scale multiply, clamp and
// layer bin, hex multiply, axial mapping, cube rounding, fixup and ring,
// output saturation and cell index.
// Reset clears the stage valid bits and loads the register defaults.
// The result side cannot stall, so the pipeline never holds.
module hex_lattice_point_locator_unit import hlpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  pos_x,
	input  logic signed [IN_W-1:0]  pos_y,
	input  logic signed [IN_W-1:0]  pos_z,
	output logic                    done,
	output logic                    inside_res,
	output logic signed [OUT_W-1:0] axial_q,
	output logic signed [OUT_W-1:0] axial_r,
	output logic [OUT_W-1:0]        ring,
	output logic signed [OUT_W-1:0] layer,
	output logic [IDX_W-1:0]        cell_index,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [3:0]              cfg_addr,
	input  logic [IN_W-1:0]         cfg_data
);

	cfg_t   cfg;
	front_t front_d;
	hex_t   hex_d;
	logic   front_valid, hex_valid;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	hlpl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	hlpl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (start && !busy),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.out_valid (front_valid),
		.dout      (front_d)
	);

	hlpl_hex u_hex (
		.clk       (clk),
		.arst_n    (arst_n),
		.flat_top  (cfg.flat_top),
		.in_valid  (front_valid),
		.din       (front_d),
		.out_valid (hex_valid),
		.dout      (hex_d)
	);

	hlpl_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (hex_valid),
		.din        (hex_d),
		.done       (done),
		.inside_res (inside_res),
		.axial_q    (axial_q),
		.axial_r    (axial_r),
		.ring       (ring),
		.layer      (layer),
		.cell_index (cell_index)
	);

endmodule

[design/hlpl_cfg.sv]
module hlpl_cfg import hlpl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [3:0]      wr_addr,
	input  logic [IN_W-1:0] wr_data,
	output cfg_t            cfg
);

	logic signed [IN_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [IN_W-1:0]        inv_pitch_q, inv_pitch_z_q;
	logic [RC_W-1:0]        ring_count_q;
	logic [LC_W-1:0]        layer_count_q;
	logic                   flat_top_q;
	logic [WW_W-1:0]        ww_q;
	logic [RC_W-1:0]        rc;
	logic [LC_W-1:0]        lc;
	logic [W_W-1:0]         w;
	logic [2*W_W-1:0]       w_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			origin_z_q    <= '0;
			inv_pitch_q   <= IN_W'(65536);
			inv_pitch_z_q <= IN_W'(65536);
			ring_count_q  <= RC_W'(1);
			layer_count_q <= LC_W'(1);
			flat_top_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_addr))
				REG_ORIGIN_X:    origin_x_q    <= wr_data;
				REG_ORIGIN_Y:    origin_y_q    <= wr_data;
				REG_ORIGIN_Z:    origin_z_q    <= wr_data;
				REG_INV_PITCH:   inv_pitch_q   <= wr_data;
				REG_INV_PITCH_Z: inv_pitch_z_q <= wr_data;
				REG_RING_COUNT:  ring_count_q  <= wr_data[RC_W-1:0];
				REG_LAYER_COUNT: layer_count_q <= wr_data[LC_W-1:0];
				REG_FLAT_TOP:    flat_top_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign rc   = (ring_count_q > RC_W'(MAX_RINGS)) ? RC_W'(MAX_RINGS) : ring_count_q;
	assign lc   = (layer_count_q > LC_W'(MAX_LAYERS)) ? LC_W'(MAX_LAYERS) : layer_count_q;
	assign w    = {rc, 1'b0} - W_W'(1);
	assign w_sq = w * w;

	always_ff @(posedge clk) begin
		ww_q <= w_sq[WW_W-1:0];
	end

	always_comb begin
		cfg.origin_x    = origin_x_q;
		cfg.origin_y    = origin_y_q;
		cfg.origin_z    = origin_z_q;
		cfg.inv_pitch   = inv_pitch_q;
		cfg.inv_pitch_z = inv_pitch_z_q;
		cfg.flat_top    = flat_top_q;
		cfg.rc          = rc;
		cfg.lc          = lc;
		cfg.w           = w;
		cfg.ww          = ww_q;
	end

endmodule

[design/hlpl_front.sv]
module hlpl_front import hlpl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	input  logic signed [IN_W-1:0] pos_x,
	input  logic signed [IN_W-1:0] pos_y,
	input  logic signed [IN_W-1:0] pos_z,
	output logic                   out_valid,
	output front_t                 dout
);

	localparam logic signed [PZ_W-1:0] LIM =
		{{(PZ_W-XS_W+1){1'b0}}, 1'b1, {(XS_W-2){1'b0}}};

	logic                   valid_s1, valid_s2, valid_s3;
	logic signed [D_W-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [P_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [XS_W-1:0] xs_s3, ys_s3;
	logic signed [LAY_W-1:0] layer_s3;

	logic signed [D_W-1:0]  m_xy, m_z;
	logic signed [PZ_W:0]   off;
	logic signed [PZ_W:0]   zsum;

	function automatic logic signed [XS_W-1:0] clamp_xs(input logic signed [PZ_W-1:0] v);
		logic signed [PZ_W-1:0] c;
		c = v;
		if (v > LIM)
			c = LIM;
		else if (v < -LIM)
			c = -LIM;
		clamp_xs = c[XS_W-1:0];
	endfunction

	assign m_xy = $signed({1'b0, cfg.inv_pitch});
	assign m_z  = $signed({1'b0, cfg.inv_pitch_z});
	assign off  = $signed((PZ_W+1)'(cfg.lc) << (FRAC_BITS-1));
	assign zsum = (PZ_W+1)'($signed(pz_s2[P_W-1:FRAC_BITS])) + off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= D_W'(pos_x) - D_W'(cfg.origin_x);
		dy_s1 <= D_W'(pos_y) - D_W'(cfg.origin_y);
		dz_s1 <= D_W'(pos_z) - D_W'(cfg.origin_z);

		px_s2 <= dx_s1 * m_xy;
		py_s2 <= dy_s1 * m_xy;
		pz_s2 <= dz_s1 * m_z;

		xs_s3    <= clamp_xs($signed(px_s2[P_W-1:FRAC_BITS]));
		ys_s3    <= clamp_xs($signed(py_s2[P_W-1:FRAC_BITS]));
		layer_s3 <= $signed(zsum[PZ_W:FRAC_BITS]);
	end

	assign out_valid  = valid_s3;
	assign dout.xs    = xs_s3;
	assign dout.ys    = ys_s3;
	assign dout.layer = layer_s3;

endmodule

[design/hlpl_hex.sv]
module hlpl_hex import hlpl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   flat_top,
	input  logic   in_valid,
	input  front_t din,
	output logic   out_valid,
	output hex_t   dout
);

	localparam logic signed [HK_W-1:0] HK_S = HK_W'(HK);
	localparam logic [C_W:0] HALF = (C_W+1)'(1) << (FRAC_BITS-1);

	logic valid_s4, valid_s5, valid_s6, valid_s7;

	logic signed [HP_W-1:0]  hp_s4;
	logic signed [XS_W-1:0]  b_s4;
	logic signed [LAY_W-1:0] layer_s4, layer_s5, layer_s6, layer_s7;

	logic signed [C_W-1:0] cx_s5, cy_s5, cz_s5;

	logic signed [R_W-1:0] rx_s6, ry_s6, rz_s6;
	logic [E_W-1:0]        ex_s6, ey_s6, ez_s6;

	logic signed [R_W-1:0] rq_s7, rr_s7;
	logic [R_W-1:0]        ring_s7;

	logic signed [XS_W-1:0] mul_a, mul_b;
	logic signed [C_W-1:0]  first, second, cx, cz;
	logic signed [R_W-1:0]  fx, fy, fz;
	logic [R_W-1:0]         ax, ay, az, rmax;

	function automatic logic signed [R_W-1:0] round_ha(input logic signed [C_W-1:0] v);
		logic signed [C_W:0] ve;
		logic [C_W:0]        mag;
		logic [C_W:0]        sh;
		ve  = (C_W+1)'(v);
		mag = ve[C_W] ? -ve : ve;
		sh  = (mag + HALF) >> FRAC_BITS;
		round_ha = ve[C_W] ? R_W'(-sh) : R_W'(sh);
	endfunction

	function automatic logic [E_W-1:0] round_err(input logic signed [C_W-1:0] v,
			input logic signed [R_W-1:0] r);
		logic signed [C_W:0] diff;
		logic signed [E_W-1:0] d;
		diff = ((C_W+1)'(r) <<< FRAC_BITS) - (C_W+1)'(v);
		d    = diff[E_W-1:0];
		round_err = d[E_W-1] ? E_W'(-d) : E_W'(d);
	endfunction

	function automatic logic [R_W-1:0] abs_r(input logic signed [R_W-1:0] v);
		abs_r = v[R_W-1] ? R_W'(-v) : R_W'(v);
	endfunction

	assign mul_a = flat_top ? din.ys : din.xs;
	assign mul_b = flat_top ? din.xs : din.ys;

	assign first  = C_W'($signed(hp_s4[HP_W-1:HK_BITS]));
	assign second = C_W'(b_s4) - C_W'($signed(hp_s4[HP_W-1:HK_BITS+1]));
	assign cx     = flat_top ? first : second;
	assign cz     = flat_top ? second : first;

	always_comb begin
		fx = rx_s6;
		fy = ry_s6;
		fz = rz_s6;
		priority if (ex_s6 > ey_s6 && ex_s6 > ez_s6) begin
			fx = -ry_s6 - rz_s6;
		end else if (ey_s6 > ex_s6 && ey_s6 > ez_s6) begin
			fy = -rx_s6 - rz_s6;
		end else begin
			fz = -rx_s6 - ry_s6;
		end
		ax   = abs_r(fx);
		ay   = abs_r(fy);
		az   = abs_r(fz);
		rmax = ax;
		if (ay > rmax)
			rmax = ay;
		if (az > rmax)
			rmax = az;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		hp_s4    <= mul_a * HK_S;
		b_s4     <= mul_b;
		layer_s4 <= din.layer;

		cx_s5    <= cx;
		cz_s5    <= cz;
		cy_s5    <= -cx - cz;
		layer_s5 <= layer_s4;

		rx_s6    <= round_ha(cx_s5);
		ry_s6    <= round_ha(cy_s5);
		rz_s6    <= round_ha(cz_s5);
		ex_s6    <= round_err(cx_s5, round_ha(cx_s5));
		ey_s6    <= round_err(cy_s5, round_ha(cy_s5));
		ez_s6    <= round_err(cz_s5, round_ha(cz_s5));
		layer_s6 <= layer_s5;

		rq_s7    <= fx;
		rr_s7    <= fz;
		ring_s7  <= rmax;
		layer_s7 <= layer_s6;
	end

	assign out_valid  = valid_s7;
	assign dout.rq    = rq_s7;
	assign dout.rr    = rr_s7;
	assign dout.ring  = ring_s7;
	assign dout.layer = layer_s7;

endmodule

[design/hlpl_out.sv]
module hlpl_out import hlpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	input  hex_t                    din,
	output logic                    done,
	output logic                    inside_res,
	output logic signed [OUT_W-1:0] axial_q,
	output logic signed [OUT_W-1:0] axial_r,
	output logic [OUT_W-1:0]        ring,
	output logic signed [OUT_W-1:0] layer,
	output logic [IDX_W-1:0]        cell_index
);

	logic                    valid_s8;
	logic                    inside_s8;
	logic signed [OUT_W-1:0] q_s8, r_s8, layer_s8;
	logic [OUT_W-1:0]        ring_s8;
	logic [IDX_W-1:0]        idx_s8;

	logic             in_lattice;
	logic [W_W-1:0]   m, col, row;
	logic [IDX_W-1:0] idx;

	function automatic logic signed [OUT_W-1:0] sat_r(input logic signed [R_W-1:0] v);
		if (v > R_W'(32767))
			sat_r = OUT_W'(32767);
		else if (v < -R_W'(32768))
			sat_r = OUT_W'(-32768);
		else
			sat_r = v[OUT_W-1:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_l(input logic signed [LAY_W-1:0] v);
		if (v > LAY_W'(32767))
			sat_l = OUT_W'(32767);
		else if (v < -LAY_W'(32768))
			sat_l = OUT_W'(-32768);
		else
			sat_l = v[OUT_W-1:0];
	endfunction

	assign in_lattice = (din.ring < R_W'(cfg.rc)) && !din.layer[LAY_W-1]
		&& (din.layer < $signed({1'b0, cfg.lc}));

	assign m   = W_W'(cfg.rc) - W_W'(1);
	assign col = din.rq[W_W-1:0] + m;
	assign row = din.rr[W_W-1:0] + m;
	assign idx = IDX_W'(din.layer[W_W-1:0]) * IDX_W'(cfg.ww)
		+ IDX_W'(row) * IDX_W'(cfg.w) + IDX_W'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		inside_s8 <= in_lattice;
		q_s8      <= sat_r(din.rq);
		r_s8      <= sat_r(din.rr);
		ring_s8   <= (din.ring > R_W'(65535)) ? OUT_W'(65535) : din.ring[OUT_W-1:0];
		layer_s8  <= sat_l(din.layer);
		idx_s8    <= in_lattice ? idx : '0;
	end

	assign done       = valid_s8;
	assign inside_res = inside_s8;
	assign axial_q    = q_s8;
	assign axial_r    = r_s8;
	assign ring       = ring_s8;
	assign layer      = layer_s8;
	assign cell_index = idx_s8;

endmodule

[sim/tb_hex_lattice_point_locator_unit.sv]
module tb_hex_lattice_point_locator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hlpl_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int LATENCY        = 8;
	localparam int TAIL_CYCLES    = 4 * LATENCY;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MISMATCH_SHOWN = 10;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 200;

	typedef struct packed {
		logic                    in_lattice;
		logic signed [OUT_W-1:0] q;
		logic signed [OUT_W-1:0] r;
		logic [OUT_W-1:0]        ring_no;
		logic signed [OUT_W-1:0] layer_no;
		logic [IDX_W-1:0]        idx;
	} hex_cell_t;

	typedef struct packed {
		logic signed [IN_W-1:0] org_x;
		logic signed [IN_W-1:0] org_y;
		logic signed [IN_W-1:0] org_z;
		logic [IN_W-1:0]        inv_xy;
		logic [IN_W-1:0]        inv_z;
		logic [RC_W-1:0]        rings;
		logic [LC_W-1:0]        layers;
		logic                   flat;
	} lattice_cfg_t;

	localparam lattice_cfg_t CFG_RESET = '{
		org_x: '0, org_y: '0, org_z: '0,
		inv_xy: 32'h0001_0000, inv_z: 32'h0001_0000,
		rings: 7'd1, layers: 9'd1, flat: 1'b0
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic signed [IN_W-1:0]  pos_x = '0;
	logic signed [IN_W-1:0]  pos_y = '0;
	logic signed [IN_W-1:0]  pos_z = '0;
	logic                    done;
	logic                    inside_res;
	logic signed [OUT_W-1:0] axial_q;
	logic signed [OUT_W-1:0] axial_r;
	logic [OUT_W-1:0]        ring;
	logic signed [OUT_W-1:0] layer;
	logic [IDX_W-1:0]        cell_index;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [3:0]              cfg_addr = '0;
	logic [IN_W-1:0]         cfg_data = '0;

	lattice_cfg_t lattice_cfg = CFG_RESET;
	hex_cell_t    pending_cells[$];
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           idle_pct = 0;

	hex_lattice_point_locator_unit dut (
		.clk, .arst_n, .start, .busy, .pos_x, .pos_y, .pos_z,
		.done, .inside_res, .axial_q, .axial_r, .ring, .layer, .cell_index,
		.cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
	);

	initial forever #6 clk = ~clk;

	function automatic longint scale_floor(input longint d, input logic [IN_W-1:0] mul);
		logic [63:0] mag;
		logic [63:0] prod;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		prod = mag * {32'd0, mul};
		if (d >= 0)
			return longint'(prod >> FRAC_BITS);
		return -longint'((prod + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS);
	endfunction

	function automatic longint clamp_to(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint mag_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint round_away(input longint v);
		longint half;
		half = longint'(1) <<< (FRAC_BITS - 1);
		if (v >= 0)
			return (v + half) >>> FRAC_BITS;
		return -((-v + half) >>> FRAC_BITS);
	endfunction

	function automatic logic [OUT_W-1:0] sat_s16(input longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return OUT_W'(v);
	endfunction

	function automatic hex_cell_t locate_cell(input logic signed [IN_W-1:0] px,
			input logic signed [IN_W-1:0] py, input logic signed [IN_W-1:0] pz);
		longint one, lim, rc, lc, xs, ys, t, fq, fr, cx, cy, cz;
		longint rx, ry, rz, ex, ey, ez, rg, pzs, lay, w, m, idx;
		hex_cell_t res;
		one = longint'(1) <<< FRAC_BITS;
		lim = longint'(1) <<< (20 + FRAC_BITS);
		rc = (lattice_cfg.rings > MAX_RINGS) ? longint'(MAX_RINGS) : longint'(lattice_cfg.rings);
		lc = (lattice_cfg.layers > MAX_LAYERS) ? longint'(MAX_LAYERS) :
			longint'(lattice_cfg.layers);
		xs = clamp_to(scale_floor(longint'(px) - longint'(lattice_cfg.org_x),
			lattice_cfg.inv_xy), lim);
		ys = clamp_to(scale_floor(longint'(py) - longint'(lattice_cfg.org_y),
			lattice_cfg.inv_xy), lim);
		if (lattice_cfg.flat) begin
			t = ys * HK;
			fq = t >>> HK_BITS;
			fr = xs - (t >>> (HK_BITS + 1));
		end else begin
			t = xs * HK;
			fr = t >>> HK_BITS;
			fq = ys - (t >>> (HK_BITS + 1));
		end
		cx = fq;
		cz = fr;
		cy = -cx - cz;
		rx = round_away(cx);
		ry = round_away(cy);
		rz = round_away(cz);
		ex = mag_of(rx * one - cx);
		ey = mag_of(ry * one - cy);
		ez = mag_of(rz * one - cz);
		// a tie with no strictly largest error corrects z
		if (ex > ey && ex > ez)
			rx = -ry - rz;
		else if (ey > ex && ey > ez)
			ry = -rx - rz;
		else
			rz = -rx - ry;
		rg = mag_of(rx);
		if (mag_of(ry) > rg)
			rg = mag_of(ry);
		if (mag_of(rz) > rg)
			rg = mag_of(rz);
		pzs = scale_floor(longint'(pz) - longint'(lattice_cfg.org_z), lattice_cfg.inv_z);
		lay = (pzs + lc * (one / 2)) >>> FRAC_BITS;
		res.in_lattice = (rg < rc) && (lay >= 0) && (lay < lc);
		idx = 0;
		if (res.in_lattice) begin
			w = 2 * rc - 1;
			m = rc - 1;
			idx = lay * w * w + (rz + m) * w + (rx + m);
		end
		res.q = sat_s16(rx);
		res.r = sat_s16(rz);
		res.ring_no = (rg > 65535) ? 16'hFFFF : OUT_W'(rg);
		res.layer_no = sat_s16(lay);
		res.idx = IDX_W'(idx);
		return res;
	endfunction

	function automatic void store_reg(input logic [3:0] addr, input logic [IN_W-1:0] data);
		unique case (addr)
			REG_ORIGIN_X:    lattice_cfg.org_x = data;
			REG_ORIGIN_Y:    lattice_cfg.org_y = data;
			REG_ORIGIN_Z:    lattice_cfg.org_z = data;
			REG_INV_PITCH:   lattice_cfg.inv_xy = data;
			REG_INV_PITCH_Z: lattice_cfg.inv_z = data;
			REG_RING_COUNT:  lattice_cfg.rings = data[RC_W-1:0];
			REG_LAYER_COUNT: lattice_cfg.layers = data[LC_W-1:0];
			REG_FLAT_TOP:    lattice_cfg.flat = data[0];
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		hex_cell_t got;
		hex_cell_t want;
		if (!arst_n) begin
			lattice_cfg = CFG_RESET;
			pending_cells.delete();
		end else begin
			if (done) begin
				got = {inside_res, axial_q, axial_r, ring, layer, cell_index};
				if (pending_cells.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOWN)
						$display("unexpected cell result: inside=%0b q=%0d r=%0d ring=%0d",
							got.in_lattice, got.q, got.r, got.ring_no);
				end else begin
					want = pending_cells.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MISMATCH_SHOWN)
							$display({"cell mismatch: expected inside=%0b q=%0d r=%0d ring=%0d",
								" layer=%0d index=%0d, got inside=%0b q=%0d r=%0d ring=%0d",
								" layer=%0d index=%0d"},
								want.in_lattice, want.q, want.r, want.ring_no, want.layer_no,
								want.idx, got.in_lattice, got.q, got.r, got.ring_no,
								got.layer_no, got.idx);
					end
				end
			end
			if (start && !busy)
				pending_cells = {pending_cells, locate_cell(pos_x, pos_y, pos_z)};
			if (cfg_valid && cfg_ready)
				store_reg(cfg_addr, cfg_data);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("hex_lattice_point_locator_unit test failed");
			$finish;
		end
	end

	task automatic send_point(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
			input logic [IN_W-1:0] z);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			pos_x <= $urandom;
			pos_y <= $urandom;
			pos_z <= $urandom;
			@(negedge clk);
		end
		start <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_cells.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [IN_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_lattice(input logic [IN_W-1:0] ox, input logic [IN_W-1:0] oy,
			input logic [IN_W-1:0] oz, input logic [IN_W-1:0] ixy,
			input logic [IN_W-1:0] iz, input logic [IN_W-1:0] rings_w,
			input logic [IN_W-1:0] layers_w, input logic [IN_W-1:0] flat_w);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_INV_PITCH, ixy);
		write_reg(REG_INV_PITCH_Z, iz);
		write_reg(REG_RING_COUNT, rings_w);
		write_reg(REG_LAYER_COUNT, layers_w);
		write_reg(REG_FLAT_TOP, flat_w);
	endtask

	function automatic logic [IN_W-1:0] spread_offset();
		logic [IN_W-1:0] v;
		v = $urandom >> $urandom_range(IN_W - 1);
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic logic [IN_W-1:0] pick_pitch();
		unique case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return 32'h0001_0000;
			default: return $urandom >> $urandom_range(24, 8);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] pick_count(input int bits, input int hi);
		logic [IN_W-1:0] v;
		if ($urandom_range(7) == 0)
			v = $urandom_range((1 << bits) - 1);
		else
			v = $urandom_range(hi, 1);
		return ($urandom & ~((32'd1 << bits) - 1)) | v;
	endfunction

	task automatic test_reset_defaults();
		idle_pct = 0;
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0000_8000, 32'h0000_0000, 32'h0000_0000);
		send_point(32'h0000_0000, 32'h0000_8000, 32'hFFFF_8000);
	endtask

	task automatic test_field_extremes();
		wait_drained();
		set_lattice(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1,
			MAX_RINGS, MAX_LAYERS, 1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		wait_drained();
		set_lattice(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0,
			MAX_RINGS, MAX_LAYERS, 0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		send_point(32'h1234_5678, 32'hEDCB_A987, 32'h8000_0000);
	endtask

	task automatic test_rounding_ties();
		wait_drained();
		set_lattice('0, '0, '0, 32'h0001_0000, 32'h0001_0000, MAX_RINGS, MAX_LAYERS, 0);
		send_point(32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
		send_point(32'h0000_0000, 32'hFFFF_8000, 32'h0000_0000);
		// ring edge: last ring inside, next one outside
		send_point(32'h0000_0000, 32'h003F_0000, 32'h0000_0000);
		send_point(32'h0000_0000, 32'h0040_0000, 32'h0000_0000);
		// layer edges
		send_point(32'h0000_0000, 32'h0000_0000, 32'hFF80_0000);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0080_0000);
		wait_drained();
		write_reg(REG_FLAT_TOP, 1);
		send_point(32'h0000_8000, 32'h0000_0000, 32'h0000_0000);
		send_point(32'hFFFF_8000, 32'h0000_0000, 32'h007F_FFFF);
	endtask

	task automatic test_count_limits();
		wait_drained();
		set_lattice('0, '0, '0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FF80,
			32'hFFFF_FE00, 0);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		wait_drained();
		write_reg(REG_RING_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_LAYER_COUNT, 32'hFFFF_FFFF);
		send_point(32'h0000_0000, 32'h003F_0000, 32'h0000_0000);
		send_point(32'h0000_0000, 32'h0000_0000, 32'hFF80_0000);
	endtask

	task automatic test_ignored_index();
		wait_drained();
		for (int a = REG_FLAT_TOP + 1; a < 16; a++)
			write_reg(4'(a), $urandom);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
	endtask

	task automatic test_random_lattices();
		logic [IN_W-1:0] ox, oy, oz;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			ox = $urandom_range(1) ? spread_offset() : $urandom;
			oy = $urandom_range(1) ? spread_offset() : $urandom;
			oz = $urandom_range(1) ? spread_offset() : $urandom;
			set_lattice(ox, oy, oz, pick_pitch(), pick_pitch(), pick_count(RC_W, MAX_RINGS),
				pick_count(LC_W, MAX_LAYERS), $urandom);
			unique case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 82;
				default: idle_pct = 15;
			endcase
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(7) == 0)
					send_point($urandom, $urandom, $urandom);
				else
					send_point(ox + spread_offset(), oy + spread_offset(), oz + spread_offset());
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_rounding_ties();
		test_count_limits();
		test_ignored_index();
		test_random_lattices();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_cells.size() == 0)
			$display("hex_lattice_point_locator_unit test passed");
		else
			$display("hex_lattice_point_locator_unit test failed");
		$finish;
	end

endmodule
